FILE: src/dq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Operation codes and the status flags shared by the queue modules.
// ----------------------------------------------------------------------------
package dq_pkg;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_NOP        = 3'd4
  } dq_mode_e;

  typedef struct packed {
    logic push_rejected;
    logic pop_ignored;
  } dq_flags_t;

endpackage

FILE: src/dq_ring_mem.sv
// ----------------------------------------------------------------------------
// Double-ended queue ring storage
// One write port and two registered read ports, with write-to-read forwarding.
// ----------------------------------------------------------------------------
module dq_ring_mem #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int PTR_W      = 4
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [PTR_W-1:0]      waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [PTR_W-1:0]      raddr_a_i,
  input  logic [PTR_W-1:0]      raddr_b_i,
  output logic [DATA_WIDTH-1:0] rdata_a_o,
  output logic [DATA_WIDTH-1:0] rdata_b_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_a_q;
  logic [DATA_WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_a_i)) begin
        rdata_a_q <= wdata_i;
      end else begin
        rdata_a_q <= mem[raddr_a_i];
      end
      if (we_i && (waddr_i == raddr_b_i)) begin
        rdata_b_q <= wdata_i;
      end else begin
        rdata_b_q <= mem[raddr_b_i];
      end
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: src/dq_ctrl.sv
// ----------------------------------------------------------------------------
// Double-ended queue pointer control
// Keeps the head and tail pointers and the entry count, and steers the ring.
// ----------------------------------------------------------------------------
module dq_ctrl
  import dq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int PTR_W = 4,
  parameter int CNT_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [2:0]       mode_i,
  output logic             we_o,
  output logic [PTR_W-1:0] waddr_o,
  output logic [PTR_W-1:0] rd_front_o,
  output logic [PTR_W-1:0] rd_back_o,
  output logic [CNT_W-1:0] count_o,
  output dq_flags_t        flags_o
);

  localparam logic [PTR_W-1:0] LastIdx = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(DEPTH);

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  dq_flags_t        flags_q, flags_d;
  logic             we;
  logic             full;
  logic             empty;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] idx);
    return (idx == '0) ? LastIdx : idx - PTR_W'(1);
  endfunction

  assign full  = (cnt_q == FullCnt);
  assign empty = (cnt_q == '0);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    flags_d = '0;
    we      = 1'b0;
    waddr_o = tail_q;
    case (dq_mode_e'(mode_i))
      MODE_PUSH_FRONT: begin
        if (full) begin
          flags_d.push_rejected = 1'b1;
        end else begin
          head_d  = ring_prev(head_q);
          waddr_o = ring_prev(head_q);
          we      = 1'b1;
          cnt_d   = cnt_q + CNT_W'(1);
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          flags_d.push_rejected = 1'b1;
        end else begin
          tail_d  = ring_next(tail_q);
          waddr_o = tail_q;
          we      = 1'b1;
          cnt_d   = cnt_q + CNT_W'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          flags_d.pop_ignored = 1'b1;
        end else begin
          head_d = ring_next(head_q);
          cnt_d  = cnt_q - CNT_W'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          flags_d.pop_ignored = 1'b1;
        end else begin
          tail_d = ring_prev(tail_q);
          cnt_d  = cnt_q - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign we_o       = accept_i && we;
  assign rd_front_o = head_d;
  assign rd_back_o  = ring_prev(tail_d);
  assign count_o    = cnt_q;
  assign flags_o    = flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      flags_q <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      flags_q <= flags_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("entry count exceeds depth");

  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == FullCnt) |-> head_q == tail_q)
    else $error("pointers disagree with entry count");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && we) |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("accepted push did not grow the queue");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.push_rejected |-> cnt_q == FullCnt)
    else $error("push rejected while not full");

  a_ignore_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.pop_ignored |-> cnt_q == '0)
    else $error("pop ignored while not empty");
`endif

endmodule

FILE: src/double_ended_queue.sv
// The result beat for an item is offered in the cycle after the item is accepted.
// Throughput: one item per cycle while output drains; the ring is written and both ends
// are read at the accepting edge, with the written word forwarded to the read ports.
// A new item is taken whenever the output register is empty or being drained.
// Reset clears the pointers, the count and the flags; the ring contents are not cleared.
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded double-ended queue kept as a ring in a two-read-port memory.
// ----------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         mode_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] back_value_o,
  output logic [4:0]         entry_count_o,
  output logic               is_empty_o,
  output logic               is_full_o,
  output logic               push_rejected_o,
  output logic               pop_ignored_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EXT_W = DATA_WIDTH + 32;

  logic                  accept;
  logic                  out_valid_q;
  logic                  we;
  logic [PTR_W-1:0]      waddr;
  logic [PTR_W-1:0]      rd_front;
  logic [PTR_W-1:0]      rd_back;
  logic [CNT_W-1:0]      count;
  dq_flags_t             flags;
  logic [EXT_W-1:0]      value_ext;
  logic [DATA_WIDTH-1:0] front_data;
  logic [DATA_WIDTH-1:0] back_data;
  logic [EXT_W-1:0]      front_ext;
  logic [EXT_W-1:0]      back_ext;
  logic [CNT_W+4:0]      count_ext;
  logic                  empty;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign value_ext  = {{DATA_WIDTH{1'b0}}, value_i};

  dq_ctrl #(
    .DEPTH(DEPTH),
    .PTR_W(PTR_W),
    .CNT_W(CNT_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .mode_i    (mode_i),
    .we_o      (we),
    .waddr_o   (waddr),
    .rd_front_o(rd_front),
    .rd_back_o (rd_back),
    .count_o   (count),
    .flags_o   (flags)
  );

  dq_ring_mem #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH),
    .PTR_W     (PTR_W)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (value_ext[DATA_WIDTH-1:0]),
    .re_i     (accept),
    .raddr_a_i(rd_front),
    .raddr_b_i(rd_back),
    .rdata_a_o(front_data),
    .rdata_b_o(back_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign empty     = (count == '0);
  assign front_ext = {32'b0, front_data};
  assign back_ext  = {32'b0, back_data};
  assign count_ext = {5'b0, count};

  assign out_valid_o     = out_valid_q;
  assign front_value_o   = empty ? '0 : signed'(front_ext[31:0]);
  assign back_value_o    = empty ? '0 : signed'(back_ext[31:0]);
  assign entry_count_o   = count_ext[4:0];
  assign is_empty_o      = empty;
  assign is_full_o       = (count == CNT_W'(DEPTH));
  assign push_rejected_o = flags.push_rejected;
  assign pop_ignored_o   = flags.pop_ignored;

endmodule
